// ===== rtl/cls_pkg.sv =====
`default_nettype none

package cls_pkg;

    // field widths of the request and result items
    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    // remainder unit retires one dividend bit per cycle
    localparam int ITER_W = $clog2(POS_W);

    localparam int DEPTH_DEF = 16;

    // opcodes
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
    localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // commands from the sequencer to the free map
    typedef struct packed {
        logic scan;
        logic take;
        logic give;
    } t_fm_cmd;

endpackage

`default_nettype wire

// ===== rtl/cls_req_if.sv =====
`default_nettype none

interface cls_req_if import cls_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, opcode, value, position, input ready);
    modport sink (input valid, opcode, value, position, output ready);
endinterface

`default_nettype wire

// ===== rtl/cls_res_if.sv =====
`default_nettype none

interface cls_res_if import cls_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] element;
    logic [LEN_W-1:0]        length;
    logic                    last;

    modport source (output valid, status, element, length, last, input ready);
    modport sink (input valid, status, element, length, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/cls_ram.sv =====
`default_nettype none

module cls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/cls_rem_unit.sv =====
`default_nettype none

module cls_rem_unit import cls_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [POS_W-1:0] i_dividend,
    input  wire logic [CW-1:0]    i_divisor,
    output logic                  o_done,
    output logic      [CW-1:0]    o_rem
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [POS_W-1:0]  r_dvd, n_dvd;
    logic [CW-1:0]     r_dsr, n_dsr;
    logic [CW-1:0]     r_rem, n_rem;

    logic [CW:0]       w_trial;
    logic [CW:0]       w_diff;
    logic              w_ge;

    // restoring remainder step: shift in one dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_dvd[POS_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_iter = r_iter;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_iter = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
            n_dvd  = {r_dvd[POS_W-2:0], 1'b0};
            n_iter = r_iter + ITER_W'(1);
            if (r_iter == ITER_W'(POS_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_iter <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/cls_free_map.sv =====
`default_nettype none

module cls_free_map import cls_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_fm_cmd       i_cmd,
    input  wire logic [AW-1:0] i_give_slot,
    output logic               o_found,
    output logic      [AW-1:0] o_slot
);

    // every slot below the hint is in use, so the scan starts there
    logic [DEPTH-1:0] r_free, n_free;
    logic [AW:0]      r_hint, n_hint;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic             r_busy, n_busy;

    assign o_found = r_busy && r_free[r_ptr];
    assign o_slot  = r_ptr;

    always_comb begin
        n_free = r_free;
        n_hint = r_hint;
        n_ptr  = r_ptr;
        n_busy = r_busy;
        if (i_cmd.scan) begin
            n_busy = 1'b1;
            n_ptr  = r_hint[AW-1:0];
        end else if (r_busy && !r_free[r_ptr]) begin
            n_ptr = r_ptr + AW'(1);
        end
        if (i_cmd.take) begin
            n_free[r_ptr] = 1'b0;
            n_hint        = {1'b0, r_ptr} + (AW+1)'(1);
            n_busy        = 1'b0;
        end
        if (i_cmd.give) begin
            n_free[i_give_slot] = 1'b1;
            if ({1'b0, i_give_slot} < r_hint) begin
                n_hint = {1'b0, i_give_slot};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
            r_hint <= '0;
            r_ptr  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_free <= n_free;
            r_hint <= n_hint;
            r_ptr  <= n_ptr;
            r_busy <= n_busy;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/circular_list_store.sv =====
// circular_list_store: bounded ordered list of up to DEPTH signed 32-bit values,
// kept as circular doubly linked slots (value, next, prev memories) plus a free map.
// i_req carries one operation per item (opcode, value, position); o_res returns
// result items (status, element, length, last). both are valid/ready channels.
// one request is worked at a time; i_req.ready is high only while the sequencer
// is idle. it may take the next request while a result still waits in o_res.
// work per request (D = current length, p = position):
//   insert front/back  link read, free-slot wait (scan when slots are sparse), splice
//   insert after       remainder unit for (p-1) mod D, then the link walk at one
//                      next-pointer memory read per cycle, then link read and splice
//   delete front/back  read the end slot and unlink it; delete at: divide, walk first
//   dump               one result item per element, in list order from the head
//   full, empty or unused opcode: a single result item
// the free-slot scan checks one slot per cycle and runs alongside the link reads.
// a stalled receiver simply holds the sequencer at its next result item.
// reset empties the list at once; memories need no clearing since only linked
// slots are ever read.
`default_nettype none

module circular_list_store import cls_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cls_req_if.sink    i_req,
    cls_res_if.source  o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_DIV       = 13'b0000000000010,
        S_HEAD_RD   = 13'b0000000000100,
        S_WALK      = 13'b0000000001000,
        S_LINK_RD   = 13'b0000000010000,
        S_LINK_WAIT = 13'b0000000100000,
        S_FREE_WAIT = 13'b0000001000000,
        S_WR2       = 13'b0000010000000,
        S_DEL_RD    = 13'b0000100000000,
        S_DEL_WAIT  = 13'b0001000000000,
        S_DUMP_RD   = 13'b0010000000000,
        S_DUMP_EMIT = 13'b0100000000000,
        S_RESP      = 13'b1000000000000
    } t_state;

    // control state
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_tail, n_tail;
    logic              r_o_valid, n_o_valid;

    // working registers of the current request
    logic [OP_W-1:0]   r_op, n_op;
    logic [VAL_W-1:0]  r_val, n_val;
    logic              r_solo, n_solo;
    logic [AW-1:0]     r_at, n_at;
    logic [AW-1:0]     r_after, n_after;
    logic [AW-1:0]     r_new, n_new;
    logic [AW-1:0]     r_cur, n_cur;
    logic [CW-1:0]     r_steps, n_steps;
    logic [CW-1:0]     r_k, n_k;
    logic [STAT_W-1:0] r_status, n_status;
    logic [VAL_W-1:0]  r_elem, n_elem;

    // output item register
    logic [STAT_W-1:0] r_o_status, n_o_status;
    logic [VAL_W-1:0]  r_o_elem, n_o_elem;
    logic [LEN_W-1:0]  r_o_len, n_o_len;
    logic              r_o_last, n_o_last;

    // memory ports
    logic              val_wr_en, val_rd_en;
    logic [AW-1:0]     val_wr_addr;
    logic [VAL_W-1:0]  val_wr_data, val_rd_data;
    logic              nxt_wr_en, nxt_rd_en;
    logic [AW-1:0]     nxt_wr_addr, nxt_wr_data, nxt_rd_addr, nxt_rd_data;
    logic              prv_wr_en, prv_rd_en;
    logic [AW-1:0]     prv_wr_addr, prv_wr_data, prv_rd_data;

    // shared units
    t_fm_cmd           fm_cmd;
    logic              fm_found;
    logic [AW-1:0]     fm_slot;
    logic              div_start;
    logic              div_done;
    logic [CW-1:0]     div_rem;
    logic [POS_W-1:0]  w_dividend;

    logic              w_out_free;
    logic              w_full;
    logic              w_empty;
    logic [CW-1:0]     w_k_inc;

    assign w_out_free = !r_o_valid || o_res.ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_k_inc    = r_k + CW'(1);
    // position at or below one means the head, otherwise walk (p-1) mod length
    assign w_dividend = (i_req.position <= POS_W'(1)) ? '0 : i_req.position - POS_W'(1);

    cls_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (val_wr_en),
        .i_wr_addr (val_wr_addr),
        .i_wr_data (val_wr_data),
        .i_rd_en   (val_rd_en),
        .i_rd_addr (r_cur),
        .o_rd_data (val_rd_data)
    );

    cls_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_nxt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (nxt_wr_en),
        .i_wr_addr (nxt_wr_addr),
        .i_wr_data (nxt_wr_data),
        .i_rd_en   (nxt_rd_en),
        .i_rd_addr (nxt_rd_addr),
        .o_rd_data (nxt_rd_data)
    );

    cls_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prv_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prv_wr_en),
        .i_wr_addr (prv_wr_addr),
        .i_wr_data (prv_wr_data),
        .i_rd_en   (prv_rd_en),
        .i_rd_addr (r_cur),
        .o_rd_data (prv_rd_data)
    );

    cls_free_map #(.DEPTH(DEPTH)) u_free_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (fm_cmd),
        .i_give_slot (r_cur),
        .o_found     (fm_found),
        .o_slot      (fm_slot)
    );

    cls_rem_unit #(.DEPTH(DEPTH)) u_rem_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_tail     = r_tail;
        n_op       = r_op;
        n_val      = r_val;
        n_solo     = r_solo;
        n_at       = r_at;
        n_after    = r_after;
        n_new      = r_new;
        n_cur      = r_cur;
        n_steps    = r_steps;
        n_k        = r_k;
        n_status   = r_status;
        n_elem     = r_elem;

        // output register drains when taken
        n_o_valid  = r_o_valid && !o_res.ready;
        n_o_status = r_o_status;
        n_o_elem   = r_o_elem;
        n_o_len    = r_o_len;
        n_o_last   = r_o_last;

        val_wr_en   = 1'b0;
        val_wr_addr = fm_slot;
        val_wr_data = r_val;
        val_rd_en   = 1'b0;
        nxt_wr_en   = 1'b0;
        nxt_wr_addr = fm_slot;
        nxt_wr_data = r_after;
        nxt_rd_en   = 1'b0;
        nxt_rd_addr = r_tail;
        prv_wr_en   = 1'b0;
        prv_wr_addr = fm_slot;
        prv_wr_data = r_at;
        prv_rd_en   = 1'b0;

        fm_cmd    = '0;
        div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op     = i_req.opcode;
                    n_val    = i_req.value;
                    n_status = ST_OK;
                    n_elem   = '0;
                    n_steps  = '0;
                    n_k      = '0;
                    if (i_req.opcode == OP_INS_FRONT || i_req.opcode == OP_INS_BACK ||
                        i_req.opcode == OP_INS_AFTER) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else begin
                            fm_cmd.scan = 1'b1;
                            n_solo      = w_empty;
                            if (w_empty) begin
                                n_state = S_FREE_WAIT;
                            end else if (i_req.opcode == OP_INS_AFTER) begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end else begin
                                n_at    = r_tail;
                                n_state = S_LINK_RD;
                            end
                        end
                    end else if (i_req.opcode == OP_DEL_FRONT ||
                                 i_req.opcode == OP_DEL_BACK ||
                                 i_req.opcode == OP_DEL_AT || i_req.opcode == OP_DUMP) begin
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_RESP;
                        end else if (i_req.opcode == OP_DEL_BACK) begin
                            n_cur   = r_tail;
                            n_state = S_DEL_RD;
                        end else if (i_req.opcode == OP_DEL_AT) begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end else begin
                            n_state = S_HEAD_RD;
                        end
                    end else begin
                        // unused opcode: plain ok
                        n_state = S_RESP;
                    end
                end
            end

            S_DIV: begin
                if (div_done) begin
                    n_steps = div_rem;
                    n_state = S_HEAD_RD;
                end
            end

            S_HEAD_RD: begin
                // head is the slot after the tail
                nxt_rd_en   = 1'b1;
                nxt_rd_addr = r_tail;
                n_state     = S_WALK;
            end

            S_WALK: begin
                // memory output holds the slot reached so far
                if (r_steps == '0) begin
                    if (r_op == OP_INS_AFTER) begin
                        n_at    = nxt_rd_data;
                        n_state = S_LINK_RD;
                    end else if (r_op == OP_DUMP) begin
                        n_cur   = nxt_rd_data;
                        n_state = S_DUMP_RD;
                    end else begin
                        n_cur   = nxt_rd_data;
                        n_state = S_DEL_RD;
                    end
                end else begin
                    nxt_rd_en   = 1'b1;
                    nxt_rd_addr = nxt_rd_data;
                    n_steps     = r_steps - CW'(1);
                end
            end

            S_LINK_RD: begin
                nxt_rd_en   = 1'b1;
                nxt_rd_addr = r_at;
                n_state     = S_LINK_WAIT;
            end

            S_LINK_WAIT: begin
                n_after = nxt_rd_data;
                n_state = S_FREE_WAIT;
            end

            S_FREE_WAIT: begin
                if (fm_found) begin
                    // fill the new slot; a lone element links to itself
                    fm_cmd.take = 1'b1;
                    val_wr_en   = 1'b1;
                    nxt_wr_en   = 1'b1;
                    nxt_wr_data = r_solo ? fm_slot : r_after;
                    prv_wr_en   = 1'b1;
                    prv_wr_data = r_solo ? fm_slot : r_at;
                    n_new       = fm_slot;
                    if (r_solo) begin
                        n_tail  = fm_slot;
                        n_count = r_count + CW'(1);
                        n_state = S_RESP;
                    end else begin
                        n_state = S_WR2;
                    end
                end
            end

            S_WR2: begin
                // splice the new slot between its neighbors
                nxt_wr_en   = 1'b1;
                nxt_wr_addr = r_at;
                nxt_wr_data = r_new;
                prv_wr_en   = 1'b1;
                prv_wr_addr = r_after;
                prv_wr_data = r_new;
                n_count     = r_count + CW'(1);
                if (r_op == OP_INS_BACK || (r_op == OP_INS_AFTER && r_at == r_tail)) begin
                    n_tail = r_new;
                end
                n_state = S_RESP;
            end

            S_DEL_RD: begin
                val_rd_en   = 1'b1;
                nxt_rd_en   = 1'b1;
                nxt_rd_addr = r_cur;
                prv_rd_en   = 1'b1;
                n_state     = S_DEL_WAIT;
            end

            S_DEL_WAIT: begin
                fm_cmd.give = 1'b1;
                n_elem      = val_rd_data;
                n_count     = r_count - CW'(1);
                if (r_count <= CW'(1)) begin
                    n_tail = '0;
                end else begin
                    if (r_cur == r_tail) begin
                        n_tail = prv_rd_data;
                    end
                    nxt_wr_en   = 1'b1;
                    nxt_wr_addr = prv_rd_data;
                    nxt_wr_data = nxt_rd_data;
                    prv_wr_en   = 1'b1;
                    prv_wr_addr = nxt_rd_data;
                    prv_wr_data = prv_rd_data;
                end
                n_state = S_RESP;
            end

            S_DUMP_RD: begin
                val_rd_en   = 1'b1;
                nxt_rd_en   = 1'b1;
                nxt_rd_addr = r_cur;
                n_state     = S_DUMP_EMIT;
            end

            S_DUMP_EMIT: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ST_OK;
                    n_o_elem   = val_rd_data;
                    n_o_len    = LEN_W'(r_count);
                    n_o_last   = (w_k_inc == r_count);
                    n_cur      = nxt_rd_data;
                    n_k        = w_k_inc;
                    n_state    = (w_k_inc == r_count) ? S_IDLE : S_DUMP_RD;
                end
            end

            S_RESP: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_elem   = r_elem;
                    n_o_len    = LEN_W'(r_count);
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_tail    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_tail    <= n_tail;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_solo     <= n_solo;
        r_at       <= n_at;
        r_after    <= n_after;
        r_new      <= n_new;
        r_cur      <= n_cur;
        r_steps    <= n_steps;
        r_k        <= n_k;
        r_status   <= n_status;
        r_elem     <= n_elem;
        r_o_status <= n_o_status;
        r_o_elem   <= n_o_elem;
        r_o_len    <= n_o_len;
        r_o_last   <= n_o_last;
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_res.valid   = r_o_valid;
    assign o_res.status  = r_o_status;
    assign o_res.element = r_o_elem;
    assign o_res.length  = r_o_len;
    assign o_res.last    = r_o_last;

    // a request is taken only when idle, and work always leaves idle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while previous one in progress");

    // an insert into a full list goes straight to its reply and changes nothing
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && w_full &&
        (i_req.opcode == OP_INS_FRONT || i_req.opcode == OP_INS_BACK ||
         i_req.opcode == OP_INS_AFTER)
        |=> r_state == S_RESP && $stable(r_count) && r_status == ST_FULL)
        else $error("insert into full list not rejected");

    // the link walk never runs past the list length
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_steps < r_count)
        else $error("walk step count out of range");

    // an empty status always reports an empty list
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) && r_o_status == ST_EMPTY |-> r_o_len == '0 && r_o_last)
        else $error("empty status with nonzero length");

endmodule

`default_nettype wire
